// ===== src/tdp_pkg.sv =====
// tdp_pkg: shared types and constants for the trial-division prime test.
// Used by tdp_divider and trial_division_prime_test_core; no dependencies.
`timescale 1ns / 1ps

package tdp_pkg;

    // Default width of the tested number
    localparam int TDP_NUM_WIDTH = 32;

    // Trial divisor constants
    localparam int TDP_FIRST_DIV  = 2;
    localparam int TDP_SECOND_DIV = 3;
    localparam int TDP_FIRST_LO   = 5;
    localparam int TDP_STEP_HI    = 2;   // i -> i+2
    localparam int TDP_STEP_LO    = 4;   // i+2 -> i+6
    localparam int TDP_MIN_PRIME  = 2;
    localparam int TDP_MIN_TRIAL  = 4;   // below this no division is needed

    // Status of the shared divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== src/tdp_divider.sv =====
// tdp_divider: iterative restoring divider, one quotient bit per cycle.
// Depends on tdp_pkg (div_stat_t).
`timescale 1ns / 1ps

module tdp_divider
    import tdp_pkg::*;
#(
    parameter int NUM_WIDTH = TDP_NUM_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NUM_WIDTH-1:0] dividend,
    input  logic [NUM_WIDTH-1:0] divisor,
    output div_stat_t            stat,
    output logic [NUM_WIDTH-1:0] quotient,
    output logic [NUM_WIDTH-1:0] remainder
);

    localparam int CNT_W = $clog2(NUM_WIDTH);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [NUM_WIDTH-1:0] rem_reg, rem_next;
    logic [NUM_WIDTH-1:0] quo_reg, quo_next;
    logic [NUM_WIDTH-1:0] dvs_reg, dvs_next;
    logic [NUM_WIDTH:0]   trial;

    // partial remainder with next dividend bit, minus divisor
    assign trial = {rem_reg, quo_reg[NUM_WIDTH-1]} - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_WIDTH - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial[NUM_WIDTH])
            begin
                rem_next = {rem_reg[NUM_WIDTH-2:0], quo_reg[NUM_WIDTH-1]};
                quo_next = {quo_reg[NUM_WIDTH-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[NUM_WIDTH-1:0];
                quo_next = {quo_reg[NUM_WIDTH-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== src/trial_division_prime_test_core.sv =====
// Each accepted item runs k divisions on the shared one-bit-per-cycle divider: none below 4,
// else divisors 2, 3, 5, 7, 11, 13, ... up to about 2 + sqrt(n)/3 of them, stopping at the
// first factor; the verdict then passes through ST_DONE into the out_valid register.
// Throughput: one item at a time; in_ready is high only while idle, so the next item is
// taken only after the last has left ST_DONE, later while a result waits.
// Reset: rst_n asynchronous, active low; clears sequencer and output valid. Uses tdp_pkg.
`timescale 1ns / 1ps

module trial_division_prime_test_core
    import tdp_pkg::*;
#(
    parameter int NUM_WIDTH = TDP_NUM_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [NUM_WIDTH-1:0] candidate,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 prime_flag
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIVIDE = 3'b010,
        ST_DONE   = 3'b100
    } state_t;

    // which trial divisor is in the divider
    typedef enum logic [1:0] {
        K_TWO,
        K_THREE,
        K_LO,
        K_HI
    } kind_t;

    state_t               state_reg, state_next;
    kind_t                kind_reg, kind_next;
    logic [NUM_WIDTH-1:0] n_reg, n_next;
    logic [NUM_WIDTH-1:0] d_reg, d_next;
    logic                 res_reg, res_next;
    logic                 ov_reg, ov_next;
    logic                 flag_reg, flag_next;
    logic                 div_start;
    div_stat_t            div_stat;
    logic [NUM_WIDTH-1:0] div_quo;
    logic [NUM_WIDTH-1:0] div_rem;
    logic                 rem_zero;

    tdp_divider #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (n_next),
        .divisor   (d_next),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign rem_zero = (div_rem == '0);
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        res_next   = res_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    n_next = candidate;
                    if (candidate < NUM_WIDTH'(TDP_MIN_PRIME))
                    begin
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                    else if (candidate < NUM_WIDTH'(TDP_MIN_TRIAL))
                    begin
                        res_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        d_next     = NUM_WIDTH'(TDP_FIRST_DIV);
                        kind_next  = K_TWO;
                        div_start  = 1'b1;
                        state_next = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    // default: a zero remainder ends the test as composite
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                    case (kind_reg)
                        K_TWO:
                        begin
                            if (!rem_zero)
                            begin
                                d_next     = NUM_WIDTH'(TDP_SECOND_DIV);
                                kind_next  = K_THREE;
                                div_start  = 1'b1;
                                state_next = ST_DIVIDE;
                            end
                        end
                        K_THREE:
                        begin
                            if (!rem_zero)
                            begin
                                d_next     = NUM_WIDTH'(TDP_FIRST_LO);
                                kind_next  = K_LO;
                                div_start  = 1'b1;
                                state_next = ST_DIVIDE;
                            end
                        end
                        K_LO:
                        begin
                            // i > n/i: no divisor left below the square root
                            if (d_reg > div_quo)
                                res_next = 1'b1;
                            else if (!rem_zero)
                            begin
                                d_next     = d_reg + NUM_WIDTH'(TDP_STEP_HI);
                                kind_next  = K_HI;
                                div_start  = 1'b1;
                                state_next = ST_DIVIDE;
                            end
                        end
                        default:
                        begin
                            if (!rem_zero)
                            begin
                                d_next     = d_reg + NUM_WIDTH'(TDP_STEP_LO);
                                kind_next  = K_LO;
                                div_start  = 1'b1;
                                state_next = ST_DIVIDE;
                            end
                        end
                    endcase
                end
            end
            ST_DONE:
            begin
                if (!ov_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register: loaded from DONE once the slot is free
    always_comb
    begin
        ov_next   = ov_reg;
        flag_next = flag_reg;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        if (state_reg == ST_DONE && (!ov_reg || out_ready))
        begin
            ov_next   = 1'b1;
            flag_next = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= K_TWO;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        d_reg    <= d_next;
        res_reg  <= res_next;
        flag_reg <= flag_next;
    end

    assign out_valid  = ov_reg;
    assign prime_flag = flag_reg;

endmodule

// ===== src/tdp_checker.sv =====
// tdp_checker: port-level assertions for trial_division_prime_test_core.
// Depends on tdp_pkg; bound to trial_division_prime_test_core at the end of this file.
`timescale 1ns / 1ps

module tdp_checker
    import tdp_pkg::*;
#(
    parameter int NUM_WIDTH = TDP_NUM_WIDTH
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic [NUM_WIDTH-1:0] candidate,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic                 prime_flag
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(prime_flag))
        else $error("result item dropped or changed while stalled");

    // one item at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a second item while busy");

    // 0 and 1 are not prime, answered without division
    a_small: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid
        && (candidate == NUM_WIDTH'(0) || candidate == NUM_WIDTH'(1))
        |-> ##2 out_valid && !prime_flag)
        else $error("wrong result for candidate below two");

    // 2 and 3 are prime, answered without division
    a_two_three: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid
        && (candidate == NUM_WIDTH'(2) || candidate == NUM_WIDTH'(3))
        |-> ##2 out_valid && prime_flag)
        else $error("wrong result for candidate two or three");

endmodule

bind trial_division_prime_test_core tdp_checker #(
    .NUM_WIDTH (NUM_WIDTH)
) u_tdp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .candidate  (candidate),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .prime_flag (prime_flag)
);

// ===== sim/testbench.sv =====
// Testbench for trial_division_prime_test_core: drives candidates through the
// valid/ready input, predicts each primality verdict and checks the output stream.
// Depends on tdp_pkg and the core RTL only.
`timescale 1ns / 1ps

module testbench;
    import tdp_pkg::*;

    localparam int NUM_WIDTH    = TDP_NUM_WIDTH;
    localparam int LIMIT_CYCLES = 6_000_000;
    localparam int HOLD_CYCLES  = 1500;
    localparam int DRAIN_CYCLES = 200;
    localparam int REPORT_MAX   = 10;
    localparam int RANDOM_ITEMS = 106;

    typedef struct {
        logic [NUM_WIDTH-1:0] candidate;
        logic                 prime_flag;
    } verdict_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [NUM_WIDTH-1:0] candidate = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 prime_flag;

    verdict_t pending_verdicts[$];
    int       fault_count = 0;
    int       cycle_count = 0;
    int       burst_left = 0;
    bit       hold_request = 1'b0;
    int       hold_left = 0;
    int       stall_mode = 0;
    int       stall_phase = 0;

    trial_division_prime_test_core #(
        .NUM_WIDTH(NUM_WIDTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .candidate (candidate),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .prime_flag(prime_flag)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // 6k+-1 trial division; the bound d <= n/d avoids squaring
    function automatic logic is_prime_candidate(input logic [NUM_WIDTH-1:0] value);
        logic [63:0] n;
        logic [63:0] d;
        n = 64'(value);
        if (n < TDP_MIN_PRIME)
            return 1'b0;
        if (n < TDP_MIN_TRIAL)
            return 1'b1;
        if (n % TDP_FIRST_DIV == 0 || n % TDP_SECOND_DIV == 0)
            return 1'b0;
        for (d = TDP_FIRST_LO; d <= n / d; d += TDP_STEP_HI + TDP_STEP_LO)
        begin
            if (n % d == 0 || n % (d + TDP_STEP_HI) == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Receiver: long hold on request, otherwise a stall pattern that changes mode
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (hold_request)
        begin
            out_ready <= 1'b0;
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        else
        begin
            if (stall_phase == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_phase = $urandom_range(20, 80);
            end
            stall_phase = stall_phase - 1;
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                2: out_ready <= ($urandom_range(0, 1) != 0);
                default: out_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                fault_count++;
                if (fault_count <= REPORT_MAX)
                    $display("unexpected result: prime_flag=%0b", prime_flag);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (prime_flag !== want.prime_flag)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX)
                        $display("mismatch: candidate=%0d expected prime_flag=%0b got %0b",
                                 want.candidate, want.prime_flag, prime_flag);
                end
            end
        end
    end

    // Offers one item, with random gaps between bursts; returns at the accepting edge
    task automatic send_candidate(input logic [NUM_WIDTH-1:0] value);
        int gap;
        verdict_t entry;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        in_valid  <= 1'b1;
        candidate <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        entry.candidate  = value;
        entry.prime_flag = is_prime_candidate(value);
        pending_verdicts.push_back(entry);
        burst_left--;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_verdicts.size() != 0);
    endtask

    task automatic test_edge_values();
        logic [NUM_WIDTH-1:0] values[$];
        values = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9,
                   25, 35, 49, 121, 143, 169, 289,
                   32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000,
                   32'h5555_5555, 32'hAAAA_AAAA,
                   16777213, 16752649};    // large prime, and square of 4093
        foreach (values[k])
            send_candidate(values[k]);
    endtask

    task automatic test_drained_restart();
        wait_drained();
        repeat (4)
            send_candidate($urandom_range(0, 1023));
    endtask

    // Output held off while items keep coming, so the core stalls its input
    task automatic test_output_backpressure();
        hold_request = 1'b1;
        repeat (6)
            send_candidate($urandom_range(0, 4095));
        wait_drained();
    endtask

    function automatic logic [NUM_WIDTH-1:0] pick_candidate();
        int sel;
        logic [NUM_WIDTH-1:0] value;
        sel = $urandom_range(0, 99);
        if (sel < 35)
            value = $urandom_range(0, 4095);
        else if (sel < 60)
            value = 6 * $urandom_range(1, 10922) + (($urandom_range(0, 1) != 0) ? 1 : -1);
        else if (sel < 75)
            value = $urandom_range(0, 65535);
        else if (sel < 80)
            value = $urandom_range(0, (1 << 20) - 1);
        else if (sel < 92)
        begin
            // full width but a multiple of three, so the core answers quickly
            value = $urandom;
            value = value - (value % TDP_SECOND_DIV);
        end
        else
        begin
            value = $urandom;
            value[0] = 1'b0;
        end
        return value;
    endfunction

    task automatic test_random_candidates();
        repeat (RANDOM_ITEMS)
            send_candidate(pick_candidate());
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_values();
        test_drained_restart();
        test_output_backpressure();
        test_random_candidates();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0 && pending_verdicts.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
